// ----- hdl/motor_command_frame_decoder_unit_defines.svh -----
// assertion macros used by the checker file of the motor command frame decoder
`ifndef MOTOR_COMMAND_FRAME_DECODER_UNIT_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_DECODER_UNIT_DEFINES_SVH

// property checked out of reset
`define CMDFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property that must also hold while reset is applied
`define CMDFD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cmdfd_pkg.sv -----
// shared types, constants and the scaling table of the motor command frame decoder
package cmdfd_pkg;

  localparam int FrameLen   = 8;
  localparam int NumWheels  = 4;
  localparam int QueueDepth = 2;
  localparam int ScaleNum   = 100;
  localparam int ScaleDen   = 126;
  localparam int OutWidth   = 48;

  localparam logic [6:0] StopDutyRst    = 7'd10;
  localparam logic [6:0] DutyOffsetRst  = 7'd13;
  localparam logic [7:0] DribRunDutyRst = 8'd128;
  localparam logic [7:0] DribIdleRst    = 8'd20;
  localparam logic [7:0] HeaderByte     = 8'd1;
  localparam logic [7:0] FlagOn         = 8'd1;

  typedef enum logic [1:0] {
    CFG_STOP_DUTY   = 2'd0,
    CFG_DUTY_OFFSET = 2'd1,
    CFG_DRIB_RUN    = 2'd2,
    CFG_DRIB_IDLE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0] stop_duty;
    logic [6:0] duty_offset;
    logic [7:0] drib_run_duty;
    logic [7:0] drib_idle_duty;
  } cfg_t;

  // raw command as classified by the front end
  typedef struct packed {
    logic [NumWheels-1:0][7:0] wheel;
    logic                      kick;
    logic                      drib_run;
  } cmd_t;

  typedef logic [6:0] scale_lut_t [128];

  // magnitude * 100 / 126, built at elaboration
  function automatic scale_lut_t build_scale_lut();
    scale_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      lut[i] = 7'((i * ScaleNum) / ScaleDen);
    end
    return lut;
  endfunction

  localparam scale_lut_t ScaleLut = build_scale_lut();

endpackage

// ----- hdl/cmdfd_front.sv -----
// front end: gathers bytes into frames and queues commands with a valid header
module cmdfd_front
  import cmdfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  output logic       byte_ready_o,
  input  logic [7:0] byte_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_cmd_o
);

  localparam logic [2:0] LastPos = 3'(FrameLen - 1);

  logic [2:0] pos_q, pos_d;
  logic [7:0] store_q [FrameLen-1];
  logic       hdr_ok;
  logic       at_last;
  logic       accept;

  assign at_last      = (pos_q == LastPos);
  assign hdr_ok       = (store_q[0] == HeaderByte) && (store_q[1] == HeaderByte);
  // only a closing frame with a good header needs room in the queue
  assign byte_ready_o = !at_last || !hdr_ok || push_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign push_valid_o = accept && at_last && hdr_ok;

  always_comb begin
    for (int k = 0; k < NumWheels; k++) begin
      push_cmd_o.wheel[k] = store_q[2 + k];
    end
    push_cmd_o.kick     = (store_q[6] == FlagOn);
    push_cmd_o.drib_run = (byte_i == FlagOn);
  end

  assign pos_d = at_last ? 3'd0 : pos_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !at_last) begin
      store_q[pos_q] <= byte_i;
    end
  end

endmodule

// ----- hdl/cmdfd_queue.sv -----
// short command queue between front end and back end
module cmdfd_queue
  import cmdfd_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hdl/cmdfd_back.sv -----
// back end: turns queued commands into duty values and holds the output register
module cmdfd_back
  import cmdfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutWidth-1:0] out_data_o
);

  logic [NumWheels-1:0][7:0] duty;
  logic [NumWheels-1:0]      fwd;
  logic [OutWidth-1:0]       data_d, data_q;
  logic                      valid_q;
  logic                      load;

  assign cmd_ready_o = !valid_q || out_ready_i;
  assign load        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    logic [6:0] mag;
    for (int k = 0; k < NumWheels; k++) begin
      fwd[k] = cmd_i.wheel[k][7];
      // forward bytes count down from 255, so the magnitude is the inverted low bits
      mag = fwd[k] ? ~cmd_i.wheel[k][6:0] : cmd_i.wheel[k][6:0];
      if (mag == '0) begin
        duty[k] = {1'b0, cfg_i.stop_duty};
      end else begin
        duty[k] = {1'b0, cfg_i.duty_offset} + {1'b0, ScaleLut[mag]};
      end
    end
  end

  always_comb begin
    data_d = '0;
    for (int k = 0; k < NumWheels; k++) begin
      data_d[9*k +: 8] = duty[k];
      data_d[9*k + 8]  = fwd[k];
    end
    data_d[9*NumWheels]            = cmd_i.kick;
    data_d[9*NumWheels + 1 +: 8]   = cmd_i.drib_run ? cfg_i.drib_run_duty
                                                    : cfg_i.drib_idle_duty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/motor_command_frame_decoder_unit.sv -----
// top level of the motor command frame decoder
// Usage:
//  s_axis carries one received byte per transaction in tdata. Every eighth
//  byte closes a frame; there is no resync. A frame whose bytes 0 and 1 are
//  both 1 yields one command on m_axis, other frames are dropped silently.
//  m_axis tdata holds four wheels (duty and forward bit each), the kick
//  request and the dribbler duty. The cfg channel writes the duty settings by
//  register index and is always ready; write it only while the block is idle.
//  Throughput: one byte per cycle while s_axis tready is high. After the
//  closing byte is taken, the command passes the command queue and then
//  the output register, which holds the decode of the wheel bytes.
//  When m_axis stalls, the output register holds its command and the queue
//  behind it keeps taking frames; s_axis tready drops only on a closing byte
//  with a good header while the queue is full.
//  Reset clears the byte position, the queue and the output valid and loads
//  the default duty settings; stored frame bytes are not cleared.
module motor_command_frame_decoder_unit
  import cmdfd_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] wheel1_duty, [8] wheel1_forward, [16:9] wheel2_duty, [17] wheel2_forward,
  // [25:18] wheel3_duty, [26] wheel3_forward, [34:27] wheel4_duty,
  // [35] wheel4_forward, [36] kick_request, [44:37] dribbler_duty, [47:45] zero
  output logic [OutWidth-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_duty      <= StopDutyRst;
      cfg_q.duty_offset    <= DutyOffsetRst;
      cfg_q.drib_run_duty  <= DribRunDutyRst;
      cfg_q.drib_idle_duty <= DribIdleRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STOP_DUTY:   cfg_q.stop_duty      <= cfg_data_i[6:0];
        CFG_DUTY_OFFSET: cfg_q.duty_offset    <= cfg_data_i[6:0];
        CFG_DRIB_RUN:    cfg_q.drib_run_duty  <= cfg_data_i;
        CFG_DRIB_IDLE:   cfg_q.drib_idle_duty <= cfg_data_i;
        default:         cfg_q                <= cfg_q;
      endcase
    end
  end

  cmdfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  cmdfd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  cmdfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- hdl/cmdfd_checker.sv -----
// port-level checker of the motor command frame decoder and its bind
`include "motor_command_frame_decoder_unit_defines.svh"

module cmdfd_checker
  import cmdfd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [7:0]          s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [1:0]          cfg_index_i,
  input logic [7:0]          cfg_data_i
);

  `CMDFD_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  `CMDFD_ASSERT(a_out_stable, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  `CMDFD_ASSERT_RST(a_rst_idle, clk_i,
    !rst_ni |-> !m_axis_tvalid, "result shown during reset")

  // offset plus scaled magnitude never exceeds 227, stop duty is at most 127
  `CMDFD_ASSERT(a_duty_range, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd227) && (m_axis_tdata[16:9] <= 8'd227) && (m_axis_tdata[25:18] <= 8'd227) && (m_axis_tdata[34:27] <= 8'd227), "wheel duty out of range")

endmodule

bind motor_command_frame_decoder_unit cmdfd_checker u_cmdfd_checker (.*);
